@@ rtl/sha_pkg.sv @@
// shared types and constants for the sha-256 byte stream hasher
// depends on nothing; imported by every module of the block
package sha_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_last;
      logic       no_byte;
   } sha_item_type;

   // command from the front to the back: one 512-bit block and whether it ends the message
   typedef struct packed {
      logic [511:0] block;
      logic         final_block;
   } sha_cmd_type;

   localparam logic [255:0] SHA_INIT_H = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [7:0] PAD_BYTE = 8'h80;

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k;
      begin
         case (t)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
         endcase
         return k;
      end
   endfunction

endpackage

@@ rtl/sha_front.sv @@
// front end: packs bytes into 512-bit blocks, counts length and builds padding
// depends on sha_pkg
module sha_front
   import sha_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  sha_item_type req_item,
   output logic         cmd_valid,
   input  logic         cmd_ready,
   output sha_cmd_type  cmd
);

   typedef enum logic [1:0] {ST_BYTES, ST_PAD, ST_ZERO, ST_LEN} state_type;

   state_type     state_ff, state_in;
   logic [511:0]  blk_ff, blk_in;
   logic [5:0]    pos_ff, pos_in;
   logic [60:0]   count_ff, count_in;
   logic          cmd_valid_ff, cmd_valid_in;
   sha_cmd_type   cmd_ff, cmd_in;

   logic          slot_free;
   logic          put_en;
   logic [7:0]    put_byte;
   logic          put_final;
   logic [63:0]   bit_len;
   logic [8:0]    bit_sel;
   logic [511:0]  blk_put;

   assign slot_free = !cmd_valid_ff || cmd_ready;
   assign bit_len   = {count_ff, 3'b000};
   assign bit_sel   = 9'd504 - {pos_ff, 3'b000};
   assign req_ready = (state_ff == ST_BYTES) && slot_free;

   always_comb begin
      blk_put = blk_ff;
      blk_put[bit_sel +: 8] = put_byte;
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      put_en       = 1'b0;
      put_byte     = 8'h00;
      put_final    = 1'b0;
      cmd_valid_in = cmd_valid_ff && !cmd_ready;
      cmd_in       = cmd_ff;
      unique case (state_ff)
         ST_BYTES: begin
            if (req_valid && req_ready) begin
               if (!req_item.no_byte) begin
                  put_en   = 1'b1;
                  put_byte = req_item.data_byte;
                  count_in = count_ff + 61'd1;
               end
               if (req_item.is_last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (slot_free) begin
               put_en   = 1'b1;
               put_byte = PAD_BYTE;
               state_in = (pos_ff == 6'd55) ? ST_LEN : ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (slot_free) begin
               put_en   = 1'b1;
               put_byte = 8'h00;
               if (pos_ff == 6'd55) begin
                  state_in = ST_LEN;
               end
            end
         end
         ST_LEN: begin
            if (slot_free) begin
               put_en   = 1'b1;
               put_byte = bit_len[{3'd7 - pos_ff[2:0], 3'b000} +: 8];
               if (pos_ff == 6'd63) begin
                  put_final = 1'b1;
                  state_in  = ST_BYTES;
                  count_in  = '0;
               end
            end
         end
         default: state_in = ST_BYTES;
      endcase
      blk_in = put_en ? blk_put : blk_ff;
      if (put_en) begin
         pos_in = pos_ff + 6'd1;
         if (pos_ff == 6'd63) begin
            cmd_valid_in      = 1'b1;
            cmd_in.block      = blk_put;
            cmd_in.final_block = put_final;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BYTES;
         pos_ff       <= '0;
         count_ff     <= '0;
         cmd_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         cmd_valid_ff <= cmd_valid_in;
      end
      blk_ff <= blk_in;
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = cmd_valid_ff;
   assign cmd       = cmd_ff;

endmodule

@@ rtl/sha_core.sv @@
// back end: 64-round compression, one round per cycle, then digest word output
// depends on sha_pkg
module sha_core
   import sha_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   output logic         cmd_ready,
   input  sha_cmd_type  cmd,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [31:0]  rsp_digest_word,
   output logic [2:0]   rsp_word_index,
   output logic         rsp_last_word
);

   typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_ADD, ST_OUT} state_type;

   state_type     state_ff, state_in;
   logic [255:0]  hash_ff, hash_in;
   logic [255:0]  vars_ff, vars_in;
   logic [511:0]  sched_ff, sched_in;
   logic [5:0]    round_ff, round_in;
   logic          final_ff, final_in;
   logic [2:0]    widx_ff, widx_in;

   logic [31:0] a, b, c, d, e, f, g, h, w, t1, t2, s0, s1, wn, x2, x15;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   always_comb begin
      {a, b, c, d, e, f, g, h} = vars_ff;
      w   = sched_ff[511 -: 32];
      // schedule window: word 0 is current, next word from words 0, 1, 9, 14
      x2  = sched_ff[511 - 14*32 -: 32];
      x15 = sched_ff[511 - 32 -: 32];
      s0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
      s1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
      wn  = s1 + sched_ff[511 - 9*32 -: 32] + s0 + w;
      t1  = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
            + round_k(round_ff) + w;
      t2  = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
   end

   assign cmd_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      hash_in  = hash_ff;
      vars_in  = vars_ff;
      sched_in = sched_ff;
      round_in = round_ff;
      final_in = final_ff;
      widx_in  = widx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               vars_in  = hash_ff;
               sched_in = cmd.block;
               final_in = cmd.final_block;
               round_in = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            vars_in  = {t1 + t2, a, b, c, d + t1, e, f, g};
            sched_in = {sched_ff[479:0], wn};
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i*32 +: 32] = hash_ff[i*32 +: 32] + vars_ff[i*32 +: 32];
            end
            widx_in  = '0;
            state_in = final_ff ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               widx_in = widx_ff + 3'd1;
               if (widx_ff == 3'd7) begin
                  hash_in  = SHA_INIT_H;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hash_ff  <= SHA_INIT_H;
         widx_ff  <= '0;
         round_ff <= '0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hash_ff  <= hash_in;
         widx_ff  <= widx_in;
         round_ff <= round_in;
         final_ff <= final_in;
      end
      vars_ff  <= vars_in;
      sched_ff <= sched_in;
   end

   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = hash_ff[255 - {widx_ff, 5'b00000} -: 32];
   assign rsp_word_index  = widx_ff;
   assign rsp_last_word   = (widx_ff == 3'd7);

endmodule

@@ rtl/sha256_byte_stream_hasher_top.sv @@
// sha-256 byte stream hasher top level: front packer, block register, compression core
// depends on sha_pkg, sha_front, sha_core
// Takes one message byte per beat and returns the eight 32-bit SHA-256 digest
// words, most significant first, after the beat marked is_last. A beat with
// no_byte set carries no byte (use it with is_last to end an empty message).
// Bytes are taken one per cycle into the block being filled, while the front
// is in its byte state and its block slot is free; a full block is handed to
// the compression core, which accepts it when idle, runs its rounds and then
// the final add, so while one block compresses the next can be filled.
// Padding bytes are added after the last beat (up to 64, or up to 72 when an
// extra block is needed), then the final block is compressed and the digest
// comes out one word per beat.
module sha256_byte_stream_hasher_top
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_is_last,
   input  logic        req_no_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   sha_item_type item;
   sha_cmd_type  cmd;
   logic         cmd_valid;
   logic         cmd_ready;

   assign item.data_byte = req_data_byte;
   assign item.is_last   = req_is_last;
   assign item.no_byte   = req_no_byte;

   sha_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (item),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   sha_core u_core (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd_ready       (cmd_ready),
      .cmd             (cmd),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

endmodule
